[hw/rtl/sesc_pkg.sv]
// Package for the surface element store/convert unit.
// Types, element codes, controller commands and conversion functions.
// No dependencies.
package sesc_pkg;

   localparam int MaxElements = 16384;
   localparam int IdxW = $clog2(MaxElements);

   localparam logic [3:0] ET_F32 = 4'd0;
   localparam logic [3:0] ET_F64 = 4'd1;
   localparam logic [3:0] ET_F16 = 4'd2;
   localparam logic [3:0] ET_S8  = 4'd3;
   localparam logic [3:0] ET_S16 = 4'd4;
   localparam logic [3:0] ET_S32 = 4'd5;
   localparam logic [3:0] ET_U8  = 4'd6;
   localparam logic [3:0] ET_U16 = 4'd7;
   localparam logic [3:0] ET_U32 = 4'd8;

   localparam logic [2:0] CSR_ID     = 3'd0;
   localparam logic [2:0] CSR_ENABLE = 3'd1;
   localparam logic [2:0] CSR_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_TYPE   = 3'd4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] surface_select;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] read_value;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic check;    // index product done: evaluate and access memory
      logic convert;  // memory data valid: build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
   } sts_type;

   // position of leading one in a 32-bit value (value nonzero)
   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
      logic [7:0]  e;
      logic [22:0] m;
      logic [4:0]  p;
      logic [22:0] mn;
      e = f[30:23];
      m = f[22:0];
      if (e == 8'hFF) begin
         if (m != 23'd0) return {f[31], 11'h7FF, 1'b1, m[21:0], 29'd0};
         return {f[31], 11'h7FF, 52'd0};
      end
      if (e == 8'd0) begin
         if (m == 23'd0) return {f[31], 63'd0};
         p = lead_one({9'd0, m});
         mn = m << (5'd23 - p);
         return {f[31], 11'(11'd874 + 11'(p)), mn, 29'd0};
      end
      return {f[31], 11'(11'(e) + 11'd896), m, 29'd0};
   endfunction

   function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
      logic [10:0] e;
      logic [51:0] m;
      logic signed [12:0] ef;
      logic [63:0] sig;
      logic [63:0] sh;
      logic [63:0] q;
      logic [63:0] rem, half;
      logic [5:0]  shift;
      e = d[62:52];
      m = d[51:0];
      if (e == 11'h7FF) begin
         if (m != 52'd0) return {d[63], 8'hFF, 1'b1, m[50:29]};
         return {d[63], 8'hFF, 23'd0};
      end
      if (e == 11'd0) return {d[63], 31'd0};
      ef = $signed({2'b00, e}) - 13'sd896;
      if (ef >= 13'sd255) return {d[63], 8'hFF, 23'd0};
      if (ef < -13'sd25) return {d[63], 31'd0};
      sig = {11'd0, 1'b1, m};
      if (ef >= 13'sd1) shift = 6'd29;
      else shift = 6'(13'sd30 - ef);
      q = sig >> shift;
      sh = 64'd1 << shift;
      rem = sig & (sh - 64'd1);
      half = sh >> 1;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (ef >= 13'sd1) return {d[63], 31'({ef[7:0] - 8'd1, 23'd0} + q[31:0])};
      return {d[63], q[30:0]};
   endfunction

   function automatic logic [15:0] f32_to_f16(input logic [31:0] f);
      logic [7:0] e;
      logic signed [9:0] eh;
      logic [10:0] mh;
      e = f[30:23];
      eh = $signed({2'b00, e}) - 10'sd112;
      if (e == 8'hFF && f[22:0] != 23'd0) return {f[31], 15'h7FFF};
      if (eh >= 10'sd31) return {f[31], 15'h7C00};
      if (eh <= 10'sd0) begin
         if (eh < -10'sd10) return {f[31], 15'd0};
         mh = {1'b1, f[22:13]} >> 4'(10'sd1 - eh);
         return {f[31], 4'd0, mh};
      end
      return {f[31], eh[4:0], f[22:13]};
   endfunction

   function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
      logic [4:0] e;
      logic [9:0] m;
      logic [4:0] p;
      logic [9:0] mn;
      e = h[14:10];
      m = h[9:0];
      if (e == 5'd31) return m != 10'd0 ? {h[15], 31'h7FC00000} : {h[15], 31'h7F800000};
      if (e == 5'd0) begin
         if (m == 10'd0) return {h[15], 31'd0};
         p = lead_one({22'd0, m});
         mn = m << (5'd10 - p);
         return {h[15], 8'(8'd103 + 8'(p)), mn, 13'd0};
      end
      return {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
   endfunction

   // nbits: 8,16,32
   function automatic logic [31:0] f32_to_int(input logic [31:0] f, input logic [5:0] nbits,
                                               input logic sgn);
      logic [7:0]  e;
      logic [32:0] mag, lim;
      logic [32:0] mask;
      e = f[30:23];
      mask = (33'd1 << nbits) - 33'd1;
      if (e == 8'hFF && f[22:0] != 23'd0) return 32'd0;
      if (e < 8'd127) mag = 33'd0;
      else if (e >= 8'd159) mag = 33'h1_0000_0000;
      else if (e >= 8'd150) mag = {9'd0, 1'b1, f[22:0]} << (e - 8'd150);
      else mag = {9'd0, 1'b1, f[22:0]} >> (8'd150 - e);
      if (sgn) begin
         if (f[31]) begin
            lim = 33'd1 << (nbits - 6'd1);
            if (mag > lim) mag = lim;
            return 32'((33'd0 - mag) & mask);
         end
         lim = (33'd1 << (nbits - 6'd1)) - 33'd1;
         return 32'(mag > lim ? lim : mag);
      end
      if (f[31]) return 32'd0;
      return 32'(mag > mask ? mask : mag);
   endfunction

   function automatic logic [31:0] int_to_f32(input logic [31:0] w, input logic [5:0] nbits,
                                               input logic sgn);
      logic [32:0] v, mask, sh, rem, half, q;
      logic        s;
      logic [4:0]  p;
      logic [5:0]  shift;
      mask = (33'd1 << nbits) - 33'd1;
      v = {1'b0, w} & mask;
      s = 1'b0;
      if (sgn && v[nbits - 6'd1]) begin
         s = 1'b1;
         v = ((33'd1 << nbits) - v) & mask;
         if (v == 33'd0) v = 33'd1 << nbits;
      end
      if (v == 33'd0) return 32'd0;
      if (v[32]) return {s, 8'd159, 23'd0};
      p = lead_one(v[31:0]);
      if (p <= 5'd23) return {s, 8'(8'd127 + 8'(p)), 23'(v << (5'd23 - p))};
      shift = 6'(p) - 6'd23;
      q = v >> shift;
      sh = 33'd1 << shift;
      rem = v & (sh - 33'd1);
      half = sh >> 1;
      if (rem > half || (rem == half && q[0])) q = q + 33'd1;
      return {s, 31'({8'(8'd126 + 8'(p)), 23'd0} + q[30:0])};
   endfunction

endpackage

[hw/rtl/surface_element_store_convert_unit.sv]
// Surface element store/convert unit: one bound 2D surface, float32 accesses.
// Top level; instantiates sesc_ctrl and sesc_datapath. Depends on sesc_pkg.
//
// One access at a time: the response is offered once the request has passed
// through the index multiply (y*width+x), the bounds check and memory access,
// and the format conversion into the response register, and it is held while
// rsp_stall is high; a new request is accepted in the cycle after the response
// is taken. The surface memory (16384 x 64 bits) has no reset and needs no
// clearing; reading an element that was never written returns undefined data.
// Configuration may be written only while no request is open.
module surface_element_store_convert_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sesc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sesc_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import sesc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sesc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   sesc_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );
endmodule

[hw/rtl/sesc_ctrl.sv]
// Controller for the surface element store/convert unit.
// Sequences capture, index check/memory access, conversion, response hold.
// Depends on sesc_pkg.
module sesc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sesc_pkg::cmd_type cmd,
   input  sesc_pkg::sts_type sts
);
   import sesc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_CONV  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_CHECK;
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in = S_CONV;
         end
         S_CONV: begin
            cmd.convert = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // reads and writes share one sequence; status kept for symmetry of checks
   logic unused_ok;
   assign unused_ok = sts.is_read;
endmodule

[hw/rtl/sesc_datapath.sv]
// Datapath for the surface element store/convert unit.
// Config registers, index multiply, bounds check, surface memory, converters.
// Depends on sesc_pkg.
module sesc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  sesc_pkg::req_type req_data,
   input  sesc_pkg::cmd_type cmd,
   output sesc_pkg::sts_type sts,
   output sesc_pkg::rsp_type rsp_data
);
   import sesc_pkg::*;

   logic [15:0] id_ff;
   logic        en_ff;
   logic [14:0] width_ff, height_ff;
   logic [3:0]  type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
         en_ff <= 1'b0;
         width_ff <= 15'd1;
         height_ff <= 15'd1;
         type_ff <= ET_F32;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ID:     id_ff <= csr_data;
            CSR_ENABLE: en_ff <= csr_data[0];
            CSR_WIDTH:  width_ff <= csr_data[14:0];
            CSR_HEIGHT: height_ff <= csr_data[14:0];
            CSR_TYPE:   type_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   req_type    req_ff;
   logic       bad_ff;
   logic [29:0] idx_ff;
   logic [63:0] wword_ff;
   logic        st_ff;
   logic [63:0] mem_q_ff;
   rsp_type     rsp_ff;
   logic [63:0] mem [MaxElements];
   logic [63:0] wword;

   // pre-check on capture; index product registered on next cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         bad_ff <= !en_ff || req_data.surface_select != id_ff
                   || req_data.coord_x[15] || req_data.coord_y[15]
                   || {1'b0, req_data.coord_x[14:0]} >= {1'b0, width_ff}
                   || {1'b0, req_data.coord_y[14:0]} >= {1'b0, height_ff};
      end
      idx_ff <= {15'd0, req_ff.coord_y[14:0]} * {15'd0, width_ff}
                + {15'd0, req_ff.coord_x[14:0]};
   end

   always_comb begin
      case (type_ff)
         ET_F64: wword = f32_to_f64(req_ff.write_value);
         ET_F16: wword = {48'd0, f32_to_f16(req_ff.write_value)};
         ET_S8:  wword = {32'd0, f32_to_int(req_ff.write_value, 6'd8, 1'b1)};
         ET_S16: wword = {32'd0, f32_to_int(req_ff.write_value, 6'd16, 1'b1)};
         ET_S32: wword = {32'd0, f32_to_int(req_ff.write_value, 6'd32, 1'b1)};
         ET_U8:  wword = {32'd0, f32_to_int(req_ff.write_value, 6'd8, 1'b0)};
         ET_U16: wword = {32'd0, f32_to_int(req_ff.write_value, 6'd16, 1'b0)};
         ET_U32: wword = {32'd0, f32_to_int(req_ff.write_value, 6'd32, 1'b0)};
         default: wword = {32'd0, req_ff.write_value};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) wword_ff <= '0;
      else wword_ff <= wword;
   end

   logic idx_bad;
   assign idx_bad = idx_ff >= 30'(MaxElements);

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         st_ff <= bad_ff || idx_bad;
         if (!bad_ff && !idx_bad && req_ff.opcode == OP_WRITE) mem[idx_ff[IdxW-1:0]] <= wword_ff;
         mem_q_ff <= mem[idx_ff[IdxW-1:0]];
      end
   end

   logic [31:0] rval;
   always_comb begin
      case (type_ff)
         ET_F64: rval = f64_to_f32(mem_q_ff);
         ET_F16: rval = f16_to_f32(mem_q_ff[15:0]);
         ET_S8:  rval = int_to_f32(mem_q_ff[31:0], 6'd8, 1'b1);
         ET_S16: rval = int_to_f32(mem_q_ff[31:0], 6'd16, 1'b1);
         ET_S32: rval = int_to_f32(mem_q_ff[31:0], 6'd32, 1'b1);
         ET_U8:  rval = int_to_f32(mem_q_ff[31:0], 6'd8, 1'b0);
         ET_U16: rval = int_to_f32(mem_q_ff[31:0], 6'd16, 1'b0);
         ET_U32: rval = int_to_f32(mem_q_ff[31:0], 6'd32, 1'b0);
         default: rval = mem_q_ff[31:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.convert) begin
         rsp_ff.status <= st_ff;
         rsp_ff.read_value <= (st_ff || req_ff.opcode == OP_WRITE) ? 32'd0 : rval;
      end
   end

   assign rsp_data = rsp_ff;
   assign sts.is_read = (req_ff.opcode == OP_READ);
endmodule

[hw/rtl/sesc_checker.sv]
// Port-level checker for surface_element_store_convert_unit, with its bind.
// Depends on sesc_pkg.
module sesc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sesc_pkg::rsp_type rsp_data
);
   import sesc_pkg::*;

   // no new request while a response is pending
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with response pending");

   // an accepted request yields a response after the multiply, check and convert states
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##4 rsp_valid) else $error("response latency");

   // error responses carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> rsp_data.read_value == 32'd0)
      else $error("error response with data");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");
endmodule

bind surface_element_store_convert_unit sesc_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
